// File: src/vrn_pkg.sv
// Shared constants and helpers for the normalized reflection pipeline.
package vrn_pkg;

  localparam int IN_W       = 24;
  localparam int OUT_W      = 19;
  localparam int INT_W      = 32;
  localparam int SUM_W      = 64;
  localparam int OUT_MAXMAG = 262143;

  // Clamp a signed value to the signed INT_W range.
  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (INT_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(64'sd1);
    if (x > hi) begin
      sat_int = hi[INT_W-1:0];
    end else if (x < lo) begin
      sat_int = lo[INT_W-1:0];
    end else begin
      sat_int = x[INT_W-1:0];
    end
  endfunction

endpackage

// File: src/vrn_unit.sv
// Pipelined magnitude unit: floor(sqrt(t * 2^(2F) / s)), one bit per stage.
module vrn_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic [vrn_pkg::SUM_W-1:0] t_sq,
  input  logic [vrn_pkg::SUM_W-1:0] s_sum,
  input  logic                     neg,
  output logic [FRAC_BITS:0]       mag,
  output logic                     mag_neg
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 1;
  localparam int SW = vrn_pkg::SUM_W;

  logic [SW-1:0] rem_r [QW];
  logic [SW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic          dneg_r[QW];

  logic [RW-1:0] root_r[RW];
  logic [QW-1:0] rad_r [RW];
  logic          sneg_r[RW];

  // Restoring division; the dividend is t followed by 2F zero bits.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [SW-1:0] rem_i;
    logic [SW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic          neg_i;
    logic          bit_i;
    logic [SW:0]   sh_nxt;
    logic [SW:0]   dif_nxt;

    if (j == 0) begin : g_first
      assign rem_i = {1'b0, t_sq[SW-1:1]};
      assign bit_i = t_sq[0];
      assign den_i = s_sum;
      assign quo_i = '0;
      assign neg_i = neg;
    end else begin : g_next
      assign rem_i = rem_r[j-1];
      assign bit_i = 1'b0;
      assign den_i = den_r[j-1];
      assign quo_i = quo_r[j-1];
      assign neg_i = dneg_r[j-1];
    end

    assign sh_nxt  = {rem_i, bit_i};
    assign dif_nxt = sh_nxt - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (sh_nxt >= {1'b0, den_i}) begin
        rem_r[j] <= dif_nxt[SW-1:0];
        quo_r[j] <= {quo_i[QW-2:0], 1'b1};
      end else begin
        rem_r[j] <= sh_nxt[SW-1:0];
        quo_r[j] <= {quo_i[QW-2:0], 1'b0};
      end
      den_r[j]  <= den_i;
      dneg_r[j] <= neg_i;
    end
  end

  // Integer square root of the quotient, trying one root bit per stage.
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RW-1:0]   root_i;
    logic [QW-1:0]   rad_i;
    logic            neg_i;
    logic [RW-1:0]   cand_nxt;
    logic [2*RW-1:0] csq_nxt;

    if (i == 0) begin : g_first
      assign root_i = '0;
      assign rad_i  = quo_r[QW-1];
      assign neg_i  = dneg_r[QW-1];
    end else begin : g_next
      assign root_i = root_r[i-1];
      assign rad_i  = rad_r[i-1];
      assign neg_i  = sneg_r[i-1];
    end

    assign cand_nxt = root_i | (RW'(1) << (RW - 1 - i));
    assign csq_nxt  = (2*RW)'(cand_nxt) * (2*RW)'(cand_nxt);

    always_ff @(posedge clk) begin
      if (csq_nxt <= (2*RW)'(rad_i)) begin
        root_r[i] <= cand_nxt;
      end else begin
        root_r[i] <= root_i;
      end
      rad_r[i]  <= rad_i;
      sneg_r[i] <= neg_i;
    end
  end

  assign mag     = root_r[RW-1];
  assign mag_neg = sneg_r[RW-1];

endmodule

// File: src/vector_reflect_normalize.sv
// Top level: reflect v about n as r = 2(n.v)n - v, then scale r to unit length.
// Throughput: one request per cycle; busy is always low since nothing stalls.
// Every stage is a fixed register step; division and square root go bit by bit.
// Reset (synchronous, rst_n low) clears only the valid bits; data is not reset.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module vector_reflect_normalize #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vrn_pkg::IN_W-1:0]     in_dir_x,
  input  logic signed [vrn_pkg::IN_W-1:0]     in_dir_y,
  input  logic signed [vrn_pkg::IN_W-1:0]     in_dir_z,
  input  logic signed [vrn_pkg::IN_W-1:0]     in_norm_x,
  input  logic signed [vrn_pkg::IN_W-1:0]     in_norm_y,
  input  logic signed [vrn_pkg::IN_W-1:0]     in_norm_z,
  output logic                                out_valid,
  output logic signed [vrn_pkg::OUT_W-1:0]    out_refl_x,
  output logic signed [vrn_pkg::OUT_W-1:0]    out_refl_y,
  output logic signed [vrn_pkg::OUT_W-1:0]    out_refl_z,
  output logic                                out_degenerate
);

  localparam int IW  = vrn_pkg::IN_W;
  localparam int OW  = vrn_pkg::OUT_W;
  localparam int KW  = vrn_pkg::INT_W;
  localparam int SW  = vrn_pkg::SUM_W;
  localparam int PW  = 2 * IW;          // n*v product
  localparam int DW  = PW + 2;          // dot product sum
  localparam int KNW = KW + IW;         // k*n product
  localparam int RW  = FRAC_BITS + 1;   // magnitude width from the unit
  localparam int LAT = 3 * FRAC_BITS + 2;
  localparam int MW  = (RW > OW) ? RW : OW;

  // The pipeline never stalls, so a request is always taken.
  assign busy = 1'b0;

  logic                 vld_r [6];
  logic signed [IW-1:0] v1_r  [3];
  logic signed [IW-1:0] n1_r  [3];
  logic signed [PW-1:0] p1_r  [3];
  logic signed [IW-1:0] v2_r  [3];
  logic signed [IW-1:0] n2_r  [3];
  logic signed [KW-1:0] k2_r;
  logic signed [IW-1:0] v3_r  [3];
  logic signed [KNW-1:0] kn3_r[3];
  logic signed [KW-1:0] r4_r  [3];
  logic [SW-1:0]        sq5_r [3];
  logic                 neg5_r[3];
  logic [SW-1:0]        sq6_r [3];
  logic                 neg6_r[3];
  logic [SW-1:0]        s6_r;
  logic                 deg6_r;

  logic signed [IW-1:0] dir_in [3];
  logic signed [IW-1:0] norm_in[3];
  logic signed [DW-1:0] dot_nxt;
  logic signed [KW-1:0] k_nxt;
  logic [SW-1:0]        s_nxt;

  assign dir_in[0]  = in_dir_x;
  assign dir_in[1]  = in_dir_y;
  assign dir_in[2]  = in_dir_z;
  assign norm_in[0] = in_norm_x;
  assign norm_in[1] = in_norm_y;
  assign norm_in[2] = in_norm_z;

  // floor(2d / 2^F) is an arithmetic shift by F-1, then clamp to 32 bits.
  assign dot_nxt = DW'(p1_r[0]) + DW'(p1_r[1]) + DW'(p1_r[2]);
  assign k_nxt   = vrn_pkg::sat_int(SW'(dot_nxt >>> (FRAC_BITS - 1)));
  assign s_nxt   = sq5_r[0] + sq5_r[1] + sq5_r[2];

  // Valid bits for the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start & ~busy;
      for (int i = 1; i < 6; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Front datapath: products, dot, k*n, r, squares, length squared.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [KNW:0]  rdif;
      logic signed [SW-1:0] rsq;
      // stage 1: component products of n.v
      v1_r[i] <= dir_in[i];
      n1_r[i] <= norm_in[i];
      p1_r[i] <= PW'(norm_in[i]) * PW'(dir_in[i]);
      // stage 2: carry v and n alongside k
      v2_r[i] <= v1_r[i];
      n2_r[i] <= n1_r[i];
      // stage 3: k times each normal component
      v3_r[i]  <= v2_r[i];
      kn3_r[i] <= KNW'(k2_r) * KNW'(n2_r[i]);
      // stage 4: r = floor(k*n / 2^F) - v, clamped
      rdif    = (KNW+1)'(kn3_r[i] >>> FRAC_BITS) - (KNW+1)'(v3_r[i]);
      r4_r[i] <= vrn_pkg::sat_int(SW'(rdif));
      // stage 5: squares and signs
      rsq       = SW'(r4_r[i]) * SW'(r4_r[i]);
      sq5_r[i]  <= rsq;
      neg5_r[i] <= r4_r[i][KW-1];
      // stage 6: hold squares for the divider
      sq6_r[i]  <= sq5_r[i];
      neg6_r[i] <= neg5_r[i];
    end
    k2_r   <= k_nxt;
    s6_r   <= s_nxt;
    deg6_r <= (s_nxt <= SW'(1));
  end

  // One magnitude unit per component.
  logic [RW-1:0] mag  [3];
  logic          mneg [3];

  for (genvar c = 0; c < 3; c++) begin : g_unit
    vrn_unit #(
      .FRAC_BITS(FRAC_BITS)
    ) u_unit (
      .clk     (clk),
      .t_sq    (sq6_r[c]),
      .s_sum   (s6_r),
      .neg     (neg6_r[c]),
      .mag     (mag[c]),
      .mag_neg (mneg[c])
    );
  end

  // Carry valid and the degenerate flag alongside the units.
  logic dly_vld_r[LAT];
  logic dly_deg_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        dly_vld_r[i] <= 1'b0;
      end
    end else begin
      dly_vld_r[0] <= vld_r[5];
      for (int i = 1; i < LAT; i++) begin
        dly_vld_r[i] <= dly_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dly_deg_r[0] <= deg6_r;
    for (int i = 1; i < LAT; i++) begin
      dly_deg_r[i] <= dly_deg_r[i-1];
    end
  end

  // Output stage: clamp magnitude, apply sign, zero on degenerate length.
  logic                 out_valid_r;
  logic signed [OW-1:0] refl_r[3];
  logic                 deg_r;
  logic signed [OW-1:0] refl_nxt[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [MW-1:0] m;
      logic [OW-1:0] mc;
      m = MW'(mag[i]);
      if (m > MW'(vrn_pkg::OUT_MAXMAG)) begin
        mc = OW'(vrn_pkg::OUT_MAXMAG);
      end else begin
        mc = m[OW-1:0];
      end
      if (dly_deg_r[LAT-1]) begin
        refl_nxt[i] = '0;
      end else if (mneg[i]) begin
        refl_nxt[i] = -$signed(mc);
      end else begin
        refl_nxt[i] = $signed(mc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dly_vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      refl_r[i] <= refl_nxt[i];
    end
    deg_r <= dly_deg_r[LAT-1];
  end

  assign out_valid      = out_valid_r;
  assign out_refl_x     = refl_r[0];
  assign out_refl_y     = refl_r[1];
  assign out_refl_z     = refl_r[2];
  assign out_degenerate = deg_r;

endmodule

// File: tb/sv/vector_reflect_normalize_chk.sv
`timescale 1ns / 1ps
// Checker for the normalized reflection block: predicts each request and compares results.
module vector_reflect_normalize_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [vrn_pkg::IN_W-1:0]  in_dir_x,
  input  logic signed [vrn_pkg::IN_W-1:0]  in_dir_y,
  input  logic signed [vrn_pkg::IN_W-1:0]  in_dir_z,
  input  logic signed [vrn_pkg::IN_W-1:0]  in_norm_x,
  input  logic signed [vrn_pkg::IN_W-1:0]  in_norm_y,
  input  logic signed [vrn_pkg::IN_W-1:0]  in_norm_z,
  input  logic                            out_valid,
  input  logic signed [vrn_pkg::OUT_W-1:0] out_refl_x,
  input  logic signed [vrn_pkg::OUT_W-1:0] out_refl_y,
  input  logic signed [vrn_pkg::OUT_W-1:0] out_refl_z,
  input  logic                            out_degenerate,
  output int                              errors,
  output int                              pending
);

  localparam int FRAC = 16;

  typedef struct packed {
    logic signed [vrn_pkg::OUT_W-1:0] x;
    logic signed [vrn_pkg::OUT_W-1:0] y;
    logic signed [vrn_pkg::OUT_W-1:0] z;
    logic                             degen;
  } unit_vec_t;

  unit_vec_t unit_q[$];

  initial errors = 0;
  initial pending = 0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(|r| * 2^FRAC / sqrt(s)), found bit by bit on squared values
  function automatic longint unsigned unit_mag(longint r, longint unsigned s);
    longint unsigned a, t, c, m;
    logic [127:0] num, prod;
    a = (r < 0) ? longint'(-r) : longint'(r);
    t = a * a;
    num = {64'd0, t} << (2 * FRAC);
    m = 0;
    for (int b = FRAC; b >= 0; b--) begin
      c = m | (64'd1 << b);
      prod = 128'(c * c) * 128'(s);
      if (prod <= num) m = c;
    end
    return m;
  endfunction

  function automatic unit_vec_t reflect_unit(longint vx, longint vy, longint vz,
                                             longint nx, longint ny, longint nz);
    longint d, k;
    longint r[3];
    longint nv[3];
    longint vv[3];
    longint unsigned s, m;
    longint val;
    logic signed [vrn_pkg::OUT_W-1:0] o[3];
    unit_vec_t res;
    nv = '{nx, ny, nz};
    vv = '{vx, vy, vz};
    d = nx * vx + ny * vy + nz * vz;
    k = clamp32((2 * d) >>> FRAC);
    s = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = clamp32(((k * nv[i]) >>> FRAC) - vv[i]);
      s += longint'(r[i] * r[i]);
    end
    if (s <= 1) begin
      res = '{x: '0, y: '0, z: '0, degen: 1'b1};
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      m = unit_mag(r[i], s);
      if (m > vrn_pkg::OUT_MAXMAG) m = vrn_pkg::OUT_MAXMAG;
      val = (r[i] < 0) ? -longint'(m) : longint'(m);
      o[i] = vrn_pkg::OUT_W'(val);
    end
    res = '{x: o[0], y: o[1], z: o[2], degen: 1'b0};
    return res;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    unit_vec_t want;
    if (rst_n && start && !busy)
      unit_q.push_back(reflect_unit(in_dir_x, in_dir_y, in_dir_z,
                                    in_norm_x, in_norm_y, in_norm_z));
    if (rst_n && out_valid) begin
      if (unit_q.size() == 0) begin
        report("out_valid with no request waiting", 1, 0);
      end else begin
        want = unit_q.pop_front();
        if (out_refl_x !== want.x) report("refl_x", out_refl_x, want.x);
        if (out_refl_y !== want.y) report("refl_y", out_refl_y, want.y);
        if (out_refl_z !== want.z) report("refl_z", out_refl_z, want.z);
        if (out_degenerate !== want.degen) report("degenerate", out_degenerate, want.degen);
      end
    end
    pending <= unit_q.size();
  end

endmodule

// File: tb/sv/vector_reflect_normalize_tb.sv
`timescale 1ns / 1ps
// Testbench top for the normalized reflection block: stimulus, watchdog and verdict.
module vector_reflect_normalize_tb;

  localparam int N_RANDOM  = 930;
  localparam int QUIET_AT  = 830;   // no idle gaps past this request
  localparam int LATENCY   = 57;
  localparam int DOG_LIMIT = 4000;

  localparam logic signed [vrn_pkg::IN_W-1:0] MAXV = 24'sh7FFFFF;
  localparam logic signed [vrn_pkg::IN_W-1:0] MINV = -24'sh800000;
  localparam logic signed [vrn_pkg::IN_W-1:0] ONE  = 24'sh010000;

  logic clk = 1'b0;
  logic rst_n, start, busy;
  logic signed [vrn_pkg::IN_W-1:0] in_dir_x, in_dir_y, in_dir_z;
  logic signed [vrn_pkg::IN_W-1:0] in_norm_x, in_norm_y, in_norm_z;
  logic out_valid, out_degenerate;
  logic signed [vrn_pkg::OUT_W-1:0] out_refl_x, out_refl_y, out_refl_z;
  int errors, pending;
  int idle_cnt;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vector_reflect_normalize u_dut (.*);

  vector_reflect_normalize_chk u_chk (.*);

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= DOG_LIMIT) begin
      $display("vector_reflect_normalize_tb: done, errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Present one request and hold it until the block takes it.
  // busy only moves on rising edges, so sample it at the falling edge.
  task automatic send(logic signed [vrn_pkg::IN_W-1:0] vx, vy, vz, nx, ny, nz);
    logic held;
    in_dir_x  <= vx;
    in_dir_y  <= vy;
    in_dir_z  <= vz;
    in_norm_x <= nx;
    in_norm_y <= ny;
    in_norm_z <= nz;
    start     <= 1'b1;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
  endtask

  // Drop start for a random idle burst now and then, only before QUIET_AT.
  task automatic maybe_gap(int idx);
    int n;
    if (idx < QUIET_AT && $urandom_range(3, 0) == 0) begin
      n = $urandom_range(9, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Component of a chosen scale: full range, moderate, unit-ish or tiny.
  function automatic logic signed [vrn_pkg::IN_W-1:0] pick_comp(int kind);
    case (kind)
      0:       return vrn_pkg::IN_W'($urandom);
      1:       return vrn_pkg::IN_W'($signed($urandom_range(2 * 262144, 0)) - 262144);
      2:       return vrn_pkg::IN_W'($signed($urandom_range(2 * 65536, 0)) - 65536);
      default: return vrn_pkg::IN_W'($signed($urandom_range(4, 0)) - 2);
    endcase
  endfunction

  initial begin
    int kind;
    idle_cnt  <= 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_dir_x  <= '0;
    in_dir_y  <= '0;
    in_dir_z  <= '0;
    in_norm_x <= '0;
    in_norm_y <= '0;
    in_norm_z <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero and near-zero lengths, field extremes, saturation, axes.
    send('0, '0, '0, '0, '0, '0);
    send(24'sd1, '0, '0, '0, '0, '0);
    send(-24'sd1, '0, '0, '0, '0, '0);
    send(24'sd1, 24'sd1, '0, '0, '0, '0);
    send(ONE, '0, '0, ONE, '0, '0);
    send(ONE, '0, '0, '0, ONE, '0);
    send(ONE, ONE, '0, '0, '0, ONE);
    send(-ONE, -ONE, ONE, '0, ONE, '0);
    send(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send(MINV, MINV, MINV, MINV, MINV, MINV);
    send(MAXV, MINV, MAXV, MINV, MAXV, MINV);
    send(MAXV, '0, '0, '0, '0, '0);
    send('0, MINV, '0, '0, '0, '0);
    send('0, '0, MAXV, '0, '0, '0);
    send(MINV, MINV, MINV, '0, '0, '0);
    send('0, '0, ONE, MAXV, MAXV, MAXV);
    send(ONE, ONE, ONE, MINV, '0, MAXV);
    send(-24'sd1, '0, '0, 24'sd1, '0, '0);
    send(24'sd3, -24'sd5, 24'sd7, 24'sd2, '0, -24'sd1);
    send(24'sd12345, -24'sd54321, 24'sd999, ONE, ONE, ONE);
    maybe_gap(0);

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9, 0);
      if (kind < 3)
        send(pick_comp(0), pick_comp(0), pick_comp(0),
             pick_comp(0), pick_comp(0), pick_comp(0));
      else if (kind < 6)
        send(pick_comp(1), pick_comp(1), pick_comp(1),
             pick_comp(2), pick_comp(2), pick_comp(2));
      else if (kind < 8)
        send(pick_comp(2), pick_comp(2), pick_comp(2),
             pick_comp(1), pick_comp(1), pick_comp(1));
      else if (kind == 8)
        send(pick_comp(3), pick_comp(3), pick_comp(3),
             pick_comp(3), pick_comp(3), pick_comp(3));
      else
        send(pick_comp(3), pick_comp(3), pick_comp(3),
             pick_comp(0), pick_comp(0), pick_comp(0));
      maybe_gap(i);
    end
    start <= 1'b0;

    // Drain: wait out every outstanding result, then idle before the verdict.
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("vector_reflect_normalize_tb: done, clean");
    end else begin
      $display("vector_reflect_normalize_tb: done, errors");
    end
    $finish;
  end

endmodule
